// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define MDU_ASSERT(name, clk, rst_n, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define MDU_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define MDU_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MDU_ASSERT(name, clk, rst_n, expr, msg)
`define MDU_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`define MDU_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/mdu_pkg.sv =====
// ----------------------------------------------------------------------------
// mdu_pkg
// Types and constants of the momentum displacement update pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mdu_pkg;

  localparam int unsigned NODE_W     = 12;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned MOM_W      = 17;
  localparam int unsigned MAXD_W     = 31;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned NUM_W      = 63;  // |d| * max_displacement
  localparam int unsigned LIM2_W     = 62;  // max_displacement squared
  localparam int unsigned NORM_W     = 64;  // sum of squares
  localparam int unsigned ROOT_W     = 32;
  localparam int unsigned QUOT_W     = 31;
  localparam int unsigned SQRT_STAGES = 32;
  localparam int unsigned DIV_STAGES  = 31;

  localparam logic [MOM_W-1:0]  MOM_ONE        = 17'd65536;
  localparam logic [DATA_W-1:0] STEP_SCALE_RST = 32'hFFFF_0000;
  localparam logic [MOM_W-1:0]  MOM_RST        = 17'd58982;
  localparam logic [MAXD_W-1:0] MAXD_RST       = 31'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_SCALE = 2'd0,
    REG_MOMENTUM   = 2'd1,
    REG_MAX_DISP   = 2'd2
  } cfg_reg_e;

  typedef logic [2:0][DATA_W-1:0] vec_t;

  typedef struct packed {
    logic              valid;
    logic [NODE_W-1:0] node;
    logic              in_range;
  } tag_t;

  typedef struct packed {
    tag_t                   tag;
    logic                   clamp;
    vec_t                   d;
    logic [2:0][NUM_W-1:0]  num;
    logic [NORM_W-1:0]      norm;
  } front_t;

  typedef struct packed {
    tag_t                   tag;
    logic                   clamp;
    vec_t                   d;
    logic [2:0][NUM_W-1:0]  num;
    logic [NORM_W-1:0]      rem;
    logic [NORM_W-1:0]      res;
  } sqrt_t;

  typedef struct packed {
    tag_t                   tag;
    logic                   clamp;
    vec_t                   d;
    logic [2:0][NUM_W-1:0]  rem;
    logic [2:0][QUOT_W-1:0] quot;
    logic [ROOT_W-1:0]      len;
  } div_t;

  typedef struct packed {
    tag_t tag;
    logic clamp;
    vec_t disp;
  } res_t;

endpackage

`default_nettype wire

// ===== design/mdu_in_if.sv =====
// ----------------------------------------------------------------------------
// mdu_in_if
// Gradient request channel: node index and 3-D gradient.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mdu_in_if;
  logic                               valid;
  logic                               ready;
  logic        [mdu_pkg::NODE_W-1:0]  node_index;
  logic signed [mdu_pkg::DATA_W-1:0]  grad_x;
  logic signed [mdu_pkg::DATA_W-1:0]  grad_y;
  logic signed [mdu_pkg::DATA_W-1:0]  grad_z;

  modport source (output valid, node_index, grad_x, grad_y, grad_z, input ready);
  modport sink (input valid, node_index, grad_x, grad_y, grad_z, output ready);
endinterface

`default_nettype wire

// ===== design/mdu_out_if.sv =====
// ----------------------------------------------------------------------------
// mdu_out_if
// Displacement result channel: node, new displacement, clamp flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mdu_out_if;
  logic                               valid;
  logic                               ready;
  logic        [mdu_pkg::NODE_W-1:0]  node_out;
  logic signed [mdu_pkg::DATA_W-1:0]  disp_x;
  logic signed [mdu_pkg::DATA_W-1:0]  disp_y;
  logic signed [mdu_pkg::DATA_W-1:0]  disp_z;
  logic                               was_clamped;

  modport source (output valid, node_out, disp_x, disp_y, disp_z, was_clamped, input ready);
  modport sink (input valid, node_out, disp_x, disp_y, disp_z, was_clamped, output ready);
endinterface

`default_nettype wire

// ===== design/mdu_ram.sv =====
// ----------------------------------------------------------------------------
// mdu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mdu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/mdu_front.sv =====
// ----------------------------------------------------------------------------
// mdu_front
// Four-stage front end: products, round/add/saturate, squares, length test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mdu_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [mdu_pkg::DATA_W-1:0]    step_scale_i,
  input  logic [mdu_pkg::MOM_W-1:0]     momentum_i,
  input  logic [mdu_pkg::MAXD_W-1:0]    max_disp_i,
  input  mdu_pkg::tag_t                 tag_i,
  input  mdu_pkg::vec_t                 grad_i,
  input  mdu_pkg::vec_t                 prev_i,
  input  logic [mdu_pkg::NODE_W-1:0]    probe_node_i,
  output logic                          hit_o,
  output mdu_pkg::front_t               out_o
);

  localparam int unsigned PG_W  = 2 * mdu_pkg::DATA_W;
  localparam int unsigned PM_W  = mdu_pkg::MOM_W + 1 + mdu_pkg::DATA_W;
  localparam int unsigned SUM_W = PG_W - mdu_pkg::FRAC_W + 1;
  localparam int unsigned DW    = mdu_pkg::DATA_W;

  localparam logic signed [PG_W-1:0] HALF_G = PG_W'(32768);
  localparam logic signed [PM_W-1:0] HALF_M = PM_W'(32768);
  localparam logic signed [SUM_W-1:0] SAT_MAX = {{(SUM_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_MIN = {{(SUM_W-DW+1){1'b1}}, {(DW-1){1'b0}}};

  // stage A: raw products
  mdu_pkg::tag_t           a_tag_q;
  logic signed [PG_W-1:0]  pg_d [3];
  logic signed [PG_W-1:0]  pg_q [3];
  logic signed [PM_W-1:0]  pm_d [3];
  logic signed [PM_W-1:0]  pm_q [3];

  // stage B: combined displacement
  mdu_pkg::tag_t           b_tag_q;
  logic signed [PG_W-1:0]  pg_rnd [3];
  logic signed [PM_W-1:0]  pm_rnd [3];
  logic signed [SUM_W-1:0] sum_w [3];
  mdu_pkg::vec_t           b_d_d;
  mdu_pkg::vec_t           b_d_q;

  // stage C: squares and scaled magnitudes
  mdu_pkg::tag_t                      c_tag_q;
  mdu_pkg::vec_t                      c_d_q;
  logic signed [PG_W-1:0]             sq_w [3];
  logic [mdu_pkg::DATA_W-1:0]         mag_w [3];
  logic [2:0][mdu_pkg::NORM_W-1:0]    sq_d;
  logic [2:0][mdu_pkg::NORM_W-1:0]    sq_q;
  logic [2:0][mdu_pkg::NUM_W-1:0]     num_d;
  logic [2:0][mdu_pkg::NUM_W-1:0]     num_q;
  logic [mdu_pkg::LIM2_W-1:0]         lim2_d;
  logic [mdu_pkg::LIM2_W-1:0]         lim2_q;

  // stage D
  logic [mdu_pkg::NORM_W-1:0]         norm_w;
  mdu_pkg::front_t                    d_d;
  mdu_pkg::front_t                    d_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pg_d[i] = $signed(step_scale_i) * $signed(grad_i[i]);
      pm_d[i] = $signed({1'b0, momentum_i}) * $signed(prev_i[i]);
    end
  end

  // round half up to Q16.16, add, saturate
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pg_rnd[i] = (pg_q[i] + HALF_G) >>> mdu_pkg::FRAC_W;
      pm_rnd[i] = (pm_q[i] + HALF_M) >>> mdu_pkg::FRAC_W;
      sum_w[i]  = SUM_W'(pg_rnd[i]) + SUM_W'(pm_rnd[i]);
      if (sum_w[i] > SAT_MAX) begin
        b_d_d[i] = SAT_MAX[DW-1:0];
      end else if (sum_w[i] < SAT_MIN) begin
        b_d_d[i] = SAT_MIN[DW-1:0];
      end else begin
        b_d_d[i] = sum_w[i][DW-1:0];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_w[i]  = $signed(b_d_q[i]) * $signed(b_d_q[i]);
      sq_d[i]  = sq_w[i];
      mag_w[i] = b_d_q[i][DW-1] ? (~b_d_q[i] + 1'b1) : b_d_q[i];
      num_d[i] = mdu_pkg::NUM_W'(mag_w[i]) * mdu_pkg::NUM_W'(max_disp_i);
    end
    lim2_d = mdu_pkg::LIM2_W'(max_disp_i) * mdu_pkg::LIM2_W'(max_disp_i);
  end

  always_comb begin
    norm_w     = sq_q[0] + sq_q[1] + sq_q[2];
    d_d.tag    = c_tag_q;
    d_d.clamp  = norm_w > mdu_pkg::NORM_W'(lim2_q);
    d_d.d      = c_d_q;
    d_d.num    = num_q;
    d_d.norm   = norm_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_tag_q <= '0;
      b_tag_q <= '0;
      c_tag_q <= '0;
      d_q     <= '0;
    end else if (en_i) begin
      a_tag_q <= tag_i;
      b_tag_q <= a_tag_q;
      c_tag_q <= b_tag_q;
      d_q     <= d_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pg_q   <= pg_d;
      pm_q   <= pm_d;
      b_d_q  <= b_d_d;
      c_d_q  <= b_d_q;
      sq_q   <= sq_d;
      num_q  <= num_d;
      lim2_q <= lim2_d;
    end
  end

  assign hit_o = (a_tag_q.valid && a_tag_q.node == probe_node_i)
              || (b_tag_q.valid && b_tag_q.node == probe_node_i)
              || (c_tag_q.valid && c_tag_q.node == probe_node_i)
              || (d_q.tag.valid && d_q.tag.node == probe_node_i);

  assign out_o = d_q;

endmodule

`default_nettype wire

// ===== design/mdu_sqrt.sv =====
// ----------------------------------------------------------------------------
// mdu_sqrt
// Pipelined integer square root of the squared length, one root bit a stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mdu_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  mdu_pkg::front_t               in_i,
  input  logic [mdu_pkg::NODE_W-1:0]    probe_node_i,
  output logic                          hit_o,
  output mdu_pkg::sqrt_t                out_o
);

  localparam int unsigned N  = mdu_pkg::SQRT_STAGES;
  localparam int unsigned NW = mdu_pkg::NORM_W;

  mdu_pkg::sqrt_t          init_w;
  mdu_pkg::sqrt_t          cur_w [N];
  mdu_pkg::sqrt_t          st_d  [N];
  mdu_pkg::sqrt_t          st_q  [N];
  logic [NW-1:0]           bit_w   [N];
  logic [NW-1:0]           trial_w [N];
  logic [N-1:0]            hit_w;

  always_comb begin
    init_w.tag   = in_i.tag;
    init_w.clamp = in_i.clamp;
    init_w.d     = in_i.d;
    init_w.num   = in_i.num;
    init_w.rem   = in_i.norm;
    init_w.res   = '0;
  end

  // digit-by-digit root: test bit 4^(N-1-k) at stage k
  always_comb begin
    for (int k = 0; k < N; k++) begin
      cur_w[k]   = (k == 0) ? init_w : st_q[k-1];
      bit_w[k]   = NW'(1) << (NW - 2 - 2 * k);
      trial_w[k] = cur_w[k].res + bit_w[k];
      st_d[k]    = cur_w[k];
      if (cur_w[k].rem >= trial_w[k]) begin
        st_d[k].rem = cur_w[k].rem - trial_w[k];
        st_d[k].res = (cur_w[k].res >> 1) + bit_w[k];
      end else begin
        st_d[k].res = cur_w[k].res >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < N; k++) begin
        st_q[k] <= '0;
      end
    end else if (en_i) begin
      for (int k = 0; k < N; k++) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < N; k++) begin
      hit_w[k] = st_q[k].tag.valid && st_q[k].tag.node == probe_node_i;
    end
  end

  assign hit_o = |hit_w;
  assign out_o = st_q[N-1];

endmodule

`default_nettype wire

// ===== design/mdu_div.sv =====
// ----------------------------------------------------------------------------
// mdu_div
// Pipelined restoring divide |d|*max / length for three lanes, sign restore.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mdu_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  mdu_pkg::sqrt_t                in_i,
  input  logic [mdu_pkg::NODE_W-1:0]    probe_node_i,
  output logic                          hit_o,
  output mdu_pkg::res_t                 out_o
);

  localparam int unsigned N  = mdu_pkg::DIV_STAGES;
  localparam int unsigned QW = mdu_pkg::QUOT_W;
  localparam int unsigned DW = mdu_pkg::DATA_W;

  mdu_pkg::div_t                init_w;
  mdu_pkg::div_t                cur_w [N];
  mdu_pkg::div_t                st_d  [N];
  mdu_pkg::div_t                st_q  [N];
  logic [mdu_pkg::NUM_W-1:0]    trial_w [N];
  logic [N-1:0]                 hit_w;
  mdu_pkg::div_t                last_w;
  logic [DW-1:0]                q_w [3];

  always_comb begin
    init_w.tag   = in_i.tag;
    init_w.clamp = in_i.clamp;
    init_w.d     = in_i.d;
    init_w.rem   = in_i.num;
    init_w.quot  = '0;
    init_w.len   = in_i.res[mdu_pkg::ROOT_W-1:0];
  end

  // quotient bit QW-1-k is settled at stage k; it never exceeds max_displacement
  always_comb begin
    for (int k = 0; k < N; k++) begin
      cur_w[k]   = (k == 0) ? init_w : st_q[k-1];
      trial_w[k] = mdu_pkg::NUM_W'(cur_w[k].len) << (QW - 1 - k);
      st_d[k]    = cur_w[k];
      for (int j = 0; j < 3; j++) begin
        if (cur_w[k].rem[j] >= trial_w[k]) begin
          st_d[k].rem[j]             = cur_w[k].rem[j] - trial_w[k];
          st_d[k].quot[j][QW-1-k]    = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < N; k++) begin
        st_q[k] <= '0;
      end
    end else if (en_i) begin
      for (int k = 0; k < N; k++) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < N; k++) begin
      hit_w[k] = st_q[k].tag.valid && st_q[k].tag.node == probe_node_i;
    end
  end

  assign last_w = st_q[N-1];

  always_comb begin
    out_o.tag   = last_w.tag;
    out_o.clamp = last_w.clamp;
    for (int j = 0; j < 3; j++) begin
      q_w[j] = {1'b0, last_w.quot[j]};
      if (!last_w.clamp) begin
        out_o.disp[j] = last_w.d[j];
      end else if (last_w.d[j][DW-1]) begin
        out_o.disp[j] = '0 - q_w[j];
      end else begin
        out_o.disp[j] = q_w[j];
      end
    end
  end

  assign hit_o = |hit_w;

  // a clamped vector has a squared length of at least one
  `MDU_ASSERT_IMP(a_len_nonzero, clk_i, rst_ni, st_q[0].tag.valid && st_q[0].clamp, st_q[0].len != '0, "clamped item with zero length")

endmodule

`default_nettype wire

// ===== design/momentum_displacement_update.sv =====
// ----------------------------------------------------------------------------
// momentum_displacement_update
// Heavy-ball displacement update per mesh node with a length clamp.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  : each request carries node_index and gradient (Q16.16).
//   out_if : one result per request, in order: node_out, disp_x/y/z, was_clamped.
//   cfg    : cfg_we_i/cfg_idx_i/cfg_data_i write step_scale (0), momentum (1,
//            clamped to 1.0) and max_displacement (2); write only when idle.
// Throughput: one request per cycle when in_if.ready is high. From the accepting
//   edge to out_if.valid: four front-end stages, 32 root stages (one root bit
//   each), 31 divide stages (one quotient bit each) and the output register;
//   the input/RAM read stage loads at the accepting edge itself.
// A request whose node is still in flight waits at in_if until that node's
//   result is written back (read-modify-write on the per-node store).
// Reset: after rst_ni rises, a clearing pass writes zero to all NODE_COUNT
//   store entries, one per cycle; in_if.ready stays low until the pass ends.
// Receiver stall: the output register holds its result; the pipeline keeps
//   taking requests until its last stage is full, then stalls as a whole.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module momentum_displacement_update #(
  parameter int unsigned NODE_COUNT = 4096
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  mdu_in_if.sink                           in_if,
  mdu_out_if.source                        out_if,
  input  logic                             cfg_we_i,
  input  logic [mdu_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mdu_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned AW = $clog2(NODE_COUNT);
  localparam int unsigned DW = mdu_pkg::DATA_W;

  // configuration
  logic [DW-1:0]                  step_scale_q;
  logic [mdu_pkg::MOM_W-1:0]      momentum_q;
  logic [mdu_pkg::MAXD_W-1:0]     max_disp_q;
  logic [mdu_pkg::MOM_W-1:0]      mom_wr;

  // store clearing
  logic                           clearing_q;
  logic [AW-1:0]                  clr_cnt_q;

  // input stage
  logic                           en;
  logic                           hit;
  logic                           accept;
  mdu_pkg::tag_t                  s1_tag_d;
  mdu_pkg::tag_t                  s1_tag_q;
  mdu_pkg::vec_t                  s1_grad_d;
  mdu_pkg::vec_t                  s1_grad_q;
  mdu_pkg::vec_t                  prev;
  logic [3*DW-1:0]                rdata;

  // store write port
  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [3*DW-1:0]                ram_wdata;
  logic                           wb;

  // pipeline parts
  logic                           front_hit;
  logic                           sqrt_hit;
  logic                           div_hit;
  mdu_pkg::front_t                front_out;
  mdu_pkg::sqrt_t                 sqrt_out;
  mdu_pkg::res_t                  res;

  // output register
  logic                           out_valid_q;
  logic [mdu_pkg::NODE_W-1:0]     out_node_q;
  mdu_pkg::vec_t                  out_disp_q;
  logic                           out_clamp_q;

  assign mom_wr = (cfg_data_i[mdu_pkg::MOM_W-1:0] > mdu_pkg::MOM_ONE)
                ? mdu_pkg::MOM_ONE : cfg_data_i[mdu_pkg::MOM_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_scale_q <= mdu_pkg::STEP_SCALE_RST;
      momentum_q   <= mdu_pkg::MOM_RST;
      max_disp_q   <= mdu_pkg::MAXD_RST;
    end else if (cfg_we_i) begin
      case (mdu_pkg::cfg_reg_e'(cfg_idx_i))
        mdu_pkg::REG_STEP_SCALE: step_scale_q <= cfg_data_i;
        mdu_pkg::REG_MOMENTUM:   momentum_q   <= mom_wr;
        mdu_pkg::REG_MAX_DISP:   max_disp_q   <= cfg_data_i[mdu_pkg::MAXD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clearing_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == AW'(NODE_COUNT - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  // whole pipeline advances unless a held result blocks a full last stage
  assign en     = !out_valid_q || out_if.ready || !res.tag.valid;
  assign hit    = (s1_tag_q.valid && s1_tag_q.node == in_if.node_index)
               || front_hit || sqrt_hit || div_hit;
  assign in_if.ready = !clearing_q && en && !hit;
  assign accept = in_if.valid && in_if.ready;

  always_comb begin
    s1_tag_d.valid    = accept;
    s1_tag_d.node     = in_if.node_index;
    s1_tag_d.in_range = 32'(in_if.node_index) < NODE_COUNT;
    s1_grad_d[0]      = in_if.grad_x;
    s1_grad_d[1]      = in_if.grad_y;
    s1_grad_d[2]      = in_if.grad_z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_tag_q <= '0;
    end else if (en) begin
      s1_tag_q <= s1_tag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_grad_q <= s1_grad_d;
    end
  end

  assign wb        = en && res.tag.valid && res.tag.in_range;
  assign ram_we    = clearing_q || wb;
  assign ram_waddr = clearing_q ? clr_cnt_q : AW'(res.tag.node);
  assign ram_wdata = clearing_q ? '0 : res.disp;

  mdu_ram #(
    .WIDTH (3 * DW),
    .DEPTH (NODE_COUNT)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (en),
    .raddr_i (AW'(in_if.node_index)),
    .rdata_o (rdata)
  );

  assign prev = s1_tag_q.in_range ? rdata : '0;

  mdu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .step_scale_i (step_scale_q),
    .momentum_i   (momentum_q),
    .max_disp_i   (max_disp_q),
    .tag_i        (s1_tag_q),
    .grad_i       (s1_grad_q),
    .prev_i       (prev),
    .probe_node_i (in_if.node_index),
    .hit_o        (front_hit),
    .out_o        (front_out)
  );

  mdu_sqrt u_sqrt (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .in_i         (front_out),
    .probe_node_i (in_if.node_index),
    .hit_o        (sqrt_hit),
    .out_o        (sqrt_out)
  );

  mdu_div u_div (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .in_i         (sqrt_out),
    .probe_node_i (in_if.node_index),
    .hit_o        (div_hit),
    .out_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en && res.tag.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && res.tag.valid) begin
      out_node_q  <= res.tag.node;
      out_disp_q  <= res.disp;
      out_clamp_q <= res.clamp;
    end
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.node_out    = out_node_q;
  assign out_if.disp_x      = out_disp_q[0];
  assign out_if.disp_y      = out_disp_q[1];
  assign out_if.disp_z      = out_disp_q[2];
  assign out_if.was_clamped = out_clamp_q;

  `MDU_ASSERT(a_no_wb_in_clear, clk_i, rst_ni, !(clearing_q && res.tag.valid), "write-back during store clear")
  `MDU_ASSERT_NEXT(a_accept_lands, clk_i, rst_ni, in_if.valid && in_if.ready, s1_tag_q.valid, "accepted request lost at input stage")
  `MDU_ASSERT_IMP(a_out_from_pipe, clk_i, rst_ni, $rose(out_valid_q), $past(res.tag.valid), "result without pipeline item")

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for momentum_displacement_update: gradient requests
// stream in with random bursts and gaps, results drain through a stalling
// receiver, and each result is checked against an in-bench predictor that
// keeps its own per-node displacement store and register copies.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import mdu_pkg::*;

  localparam int NODES      = 4096;
  localparam int SETTLE_CYC = 80;

  typedef struct {
    logic [NODE_W-1:0]        node;
    logic signed [DATA_W-1:0] gx, gy, gz;
  } grad_req_t;

  typedef struct {
    logic [NODE_W-1:0]        node;
    logic signed [DATA_W-1:0] dx, dy, dz;
    logic                     clamped;
  } disp_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  mdu_in_if  in_if ();
  mdu_out_if out_if ();

  momentum_displacement_update dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_if),
    .out_if     (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // predictor state
  longint            step_gain = -65536;
  longint            mom_gain  = 58982;
  longint unsigned   disp_cap  = 65536;
  int                store_x [NODES];
  int                store_y [NODES];
  int                store_z [NODES];

  grad_req_t grad_req_q [$];
  disp_res_t expected_disp_q [$];
  int  n_driven = 0;
  int  n_taken  = 0;
  int  n_results = 0;
  int  n_errors = 0;
  logic in_took = 1'b0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'h1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic int blend(int g, int p);
    longint t, m, s;
    t = (step_gain * longint'(g) + 32768) >>> 16;
    m = (mom_gain * longint'(p) + 32768) >>> 16;
    s = t + m;
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return int'(s);
  endfunction

  function automatic int rescale(int d, longint unsigned len);
    longint unsigned mag, q;
    mag = d < 0 ? longint'(-longint'(d)) : longint'(d);
    q = (mag * disp_cap) / len;
    return d < 0 ? int'(-longint'(q)) : int'(q);
  endfunction

  function automatic disp_res_t predict_displacement(grad_req_t r);
    disp_res_t e;
    int d [3];
    longint unsigned norm2, len;
    d[0] = blend(r.gx, store_x[r.node]);
    d[1] = blend(r.gy, store_y[r.node]);
    d[2] = blend(r.gz, store_z[r.node]);
    norm2 = 0;
    for (int i = 0; i < 3; i++) norm2 += longint'(d[i]) * longint'(d[i]);
    e.clamped = norm2 > disp_cap * disp_cap;
    if (e.clamped) begin
      len = int_sqrt(norm2);
      for (int i = 0; i < 3; i++) d[i] = rescale(d[i], len);
    end
    store_x[r.node] = d[0];
    store_y[r.node] = d[1];
    store_z[r.node] = d[2];
    e.node = r.node;
    e.dx = d[0];
    e.dy = d[1];
    e.dz = d[2];
    return e;
  endfunction

  // monitor
  always @(posedge clk_i) begin
    grad_req_t r;
    disp_res_t e;
    in_took <= in_if.valid && in_if.ready;
    if (rst_ni && in_if.valid && in_if.ready) begin
      r.node = in_if.node_index;
      r.gx = in_if.grad_x;
      r.gy = in_if.grad_y;
      r.gz = in_if.grad_z;
      expected_disp_q.push_back(predict_displacement(r));
      n_taken++;
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      n_results++;
      if (expected_disp_q.size() == 0) begin
        $display("%0t unexpected result node %0d", $realtime, out_if.node_out);
        n_errors++;
      end else begin
        e = expected_disp_q.pop_front();
        if (out_if.node_out !== e.node) begin
          $display("%0t node_out exp %0d got %0d", $realtime, e.node, out_if.node_out);
          n_errors++;
        end
        if (out_if.disp_x !== e.dx) begin
          $display("%0t disp_x exp %0d got %0d", $realtime, e.dx, out_if.disp_x);
          n_errors++;
        end
        if (out_if.disp_y !== e.dy) begin
          $display("%0t disp_y exp %0d got %0d", $realtime, e.dy, out_if.disp_y);
          n_errors++;
        end
        if (out_if.disp_z !== e.dz) begin
          $display("%0t disp_z exp %0d got %0d", $realtime, e.dz, out_if.disp_z);
          n_errors++;
        end
        if (out_if.was_clamped !== e.clamped) begin
          $display("%0t was_clamped exp %0b got %0b", $realtime, e.clamped,
                   out_if.was_clamped);
          n_errors++;
        end
      end
    end
  end

  // request driver: bursts with gaps
  int burst_left = 1;
  int gap_left = 0;
  always @(negedge clk_i) begin
    grad_req_t r;
    if (rst_ni && (in_took || !in_if.valid)) begin
      if (gap_left > 0) begin
        in_if.valid <= 1'b0;
        gap_left--;
      end else if (grad_req_q.size() > 0) begin
        r = grad_req_q.pop_front();
        in_if.node_index <= r.node;
        in_if.grad_x <= r.gx;
        in_if.grad_y <= r.gy;
        in_if.grad_z <= r.gz;
        in_if.valid <= 1'b1;
        n_driven++;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver: changing stall pattern plus one long hold-off
  int rx_mode = 0;
  int rx_cyc = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      rx_cyc++;
      if (rx_cyc % 64 == 0) rx_mode = $urandom_range(0, 2);
      if (!hold_done && n_results >= 200) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (rx_mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= $urandom_range(0, 1);
          default: out_if.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_STEP_SCALE: step_gain = longint'(signed'(val));
      REG_MOMENTUM:   mom_gain = (val[MOM_W-1:0] > MOM_ONE) ? 65536 : val[MOM_W-1:0];
      REG_MAX_DISP:   disp_cap = val[MAXD_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_grad(int node, int gx, int gy, int gz);
    grad_req_t r;
    r.node = node;
    r.gx = gx;
    r.gy = gy;
    r.gz = gz;
    grad_req_q.push_back(r);
  endtask

  function automatic int rand_grad();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: return int'($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
      3: return int'($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      4: return ($urandom_range(0, 1) == 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return int'($urandom_range(0, 511)) - 256;
    endcase
  endfunction

  task automatic queue_random(int count);
    int node;
    repeat (count) begin
      node = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 7) : $urandom_range(0, NODES - 1);
      queue_grad(node, rand_grad(), rand_grad(), rand_grad());
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (grad_req_q.size() != 0 || n_taken != n_driven || expected_disp_q.size() != 0);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.node_index = '0;
    in_if.grad_x = '0;
    in_if.grad_y = '0;
    in_if.grad_z = '0;
    out_if.ready = 1'b0;
    for (int i = 0; i < NODES; i++) begin
      store_x[i] = 0;
      store_y[i] = 0;
      store_z[i] = 0;
    end
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: extremes of fields, repeated nodes for the momentum path
    queue_grad(0, 0, 0, 0);
    queue_grad(4095, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    queue_grad(4095, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    queue_grad(1, 1, -1, 0);
    queue_grad(1, 32768, -32768, 16384);
    queue_grad(1, 0, 0, 0);
    queue_grad(2, -65536, 0, 0);
    queue_grad(2, 0, 0, 0);
    queue_grad(3, 32'sh0000_8000, 32'sh0000_4000, 32'shFFFF_8000);
    queue_grad(3, 0, 0, 0);
    queue_grad(2730, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh1234_5678);
    queue_grad(1365, 32'shAAAA_AAAA, 32'sh5555_5555, 32'shEDCB_A987);
    queue_random(90);
    wait_drained();

    // saturation: largest gain, full momentum, widest bound
    write_reg(REG_STEP_SCALE, 32'h7FFF_FFFF);
    write_reg(REG_MOMENTUM, 32'd65536);
    write_reg(REG_MAX_DISP, 32'h7FFF_FFFF);
    queue_grad(5, 32'sh7FFF_FFFF, 32'sh8000_0000, 1);
    queue_grad(5, 32'sh7FFF_FFFF, 32'sh8000_0000, -1);
    queue_random(90);
    wait_drained();

    // most negative gain, no momentum, smallest nonzero bound
    write_reg(REG_STEP_SCALE, 32'h8000_0000);
    write_reg(REG_MOMENTUM, 32'd0);
    write_reg(REG_MAX_DISP, 32'd1);
    queue_random(90);
    wait_drained();

    // momentum above one, zero bound, write to an unused index
    write_reg(REG_MOMENTUM, 32'h0001_FFFF);
    write_reg(REG_MAX_DISP, 32'd0);
    write_reg(REG_STEP_SCALE, 32'hFFFF_8000);
    write_reg(cfg_reg_e'(2'd3), 32'hFFFF_FFFF);
    queue_grad(6, 0, 0, 0);
    queue_random(80);
    wait_drained();

    repeat (3) begin
      write_reg(REG_STEP_SCALE, ($urandom_range(0, 1) == 0) ? $urandom :
                int'($urandom_range(0, 262144)) - 131072);
      write_reg(REG_MOMENTUM, $urandom_range(0, 65536));
      write_reg(REG_MAX_DISP, ($urandom_range(0, 1) == 0) ? $urandom_range(1, 32'h0004_0000) :
                $urandom_range(1, 32'h7FFF_FFFF));
      queue_random(85);
      wait_drained();
    end

    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== momentum_displacement_update.f =====
+incdir+design
design/mdu_pkg.sv
design/mdu_in_if.sv
design/mdu_out_if.sv
design/mdu_ram.sv
design/mdu_front.sv
design/mdu_sqrt.sv
design/mdu_div.sv
design/momentum_displacement_update.sv
tb/testbench.sv
